/* sv/sle_pkg.sv */
package sle_pkg;

   localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [7:0] CHAR_DELETE    = 8'h7F;
   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] CHAR_LF        = 8'h0A;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] LCD_CURSOR_LEFT = 8'h10;
   localparam logic [7:0] LCD_CLEAR       = 8'h01;

   localparam int HEAD_DEPTH  = 5;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;
   localparam int REPLY_LEN   = 12;

   localparam logic [3:0] STEP_BS_LAST    = 4'd2;
   localparam logic [3:0] STEP_REPLY_LAST = 4'd12;

   localparam logic [1:0] JOB_BACKSPACE  = 2'd0;
   localparam logic [1:0] JOB_CLEAR      = 2'd1;
   localparam logic [1:0] JOB_ECHO       = 2'd2;
   localparam logic [1:0] JOB_ECHO_REPLY = 2'd3;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] rx_byte;
   } job_type;

   typedef struct packed {
      logic       is_data;
      logic [7:0] lcd_byte;
      logic       last;
   } write_type;

   function automatic logic [7:0] reply_char(input logic [3:0] idx);
      logic [7:0] c;
      case (idx)
         4'd0:    c = "H";
         4'd1:    c = "o";
         4'd2:    c = "w";
         4'd3:    c = " ";
         4'd4:    c = "a";
         4'd5:    c = "r";
         4'd6:    c = "e";
         4'd7:    c = " ";
         4'd8:    c = "y";
         4'd9:    c = "o";
         4'd10:   c = "u";
         4'd11:   c = "?";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // one LCD write of a job, step counts from zero
   function automatic write_type lcd_write(input job_type job, input logic [3:0] step);
      write_type w;
      w.is_data  = 1'b1;
      w.lcd_byte = job.rx_byte;
      w.last     = 1'b1;
      case (job.kind)
         JOB_BACKSPACE: begin
            w.is_data  = (step == 4'd1);
            w.lcd_byte = (step == 4'd1) ? CHAR_SPACE : LCD_CURSOR_LEFT;
            w.last     = (step == STEP_BS_LAST);
         end
         JOB_CLEAR: begin
            w.is_data  = 1'b0;
            w.lcd_byte = LCD_CLEAR;
            w.last     = 1'b1;
         end
         JOB_ECHO: begin
            w.is_data  = 1'b1;
            w.lcd_byte = job.rx_byte;
            w.last     = 1'b1;
         end
         JOB_ECHO_REPLY: begin
            w.is_data  = 1'b1;
            w.lcd_byte = (step == 4'd0) ? job.rx_byte : reply_char(step - 4'd1);
            w.last     = (step == STEP_REPLY_LAST);
         end
         default: begin
            w.is_data  = 1'b1;
            w.lcd_byte = job.rx_byte;
            w.last     = 1'b1;
         end
      endcase
      return w;
   endfunction

endpackage

/* sv/serial_to_lcd_line_echo_top.sv */
// Serial-to-LCD line echo.
// req_ channel: one received serial byte per transfer (req_tdata).
// rsp_ channel: one character-LCD write per transfer; rsp_tdata is the command
//   code or character, rsp_tuser is 1 for a data write and 0 for a command,
//   rsp_tlast marks the final write caused by one received byte.
// Each byte gives 1 write (CR/LF: clear, or plain echo), 3 writes (backspace
//   or delete) or 13 writes (echo plus "How are you?" when the line reads
//   "hi" or "hello").
// The front classifies the byte and updates the line in the cycle it is
//   accepted; a four-entry job queue feeds the back, which emits one write
//   per cycle into the output register while rsp_ does not stall. A byte's
//   job passes the queue, then the back's current-job register, then the
//   output register on its way to rsp_. The back takes the next job as the
//   current one finishes; bytes are taken every cycle while the queue has room.
// Reset clears the line length, the queue and the output valid flag.
// A stall on rsp_ holds the current write; the queue then fills and
//   req_tready drops, no write is lost.
module serial_to_lcd_line_echo_top #(
   parameter int LINE_DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] rx_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] lcd_byte
   output logic       rsp_tuser,   // [0] is_data
   output logic       rsp_tlast
);

   localparam int LEN_W = $clog2(LINE_DEPTH + 1);

   logic             fq_valid, fq_ready, qb_valid, qb_ready;
   sle_pkg::job_type fq_job, qb_job;

   sle_front #(
      .LINE_DEPTH(LINE_DEPTH),
      .LEN_W     (LEN_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .job_valid (fq_valid),
      .job_ready (fq_ready),
      .job       (fq_job)
   );

   sle_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_valid (fq_valid),
      .in_ready (fq_ready),
      .in_job   (fq_job),
      .out_valid(qb_valid),
      .out_ready(qb_ready),
      .out_job  (qb_job)
   );

   sle_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (qb_valid),
      .job_ready (qb_ready),
      .job       (qb_job),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

endmodule

/* sv/sle_front.sv */
module sle_front #(
   parameter int LINE_DEPTH = 64,
   parameter int LEN_W      = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,
   output logic             job_valid,
   input  logic             job_ready,
   output sle_pkg::job_type job
);

   logic [LEN_W-1:0] line_length_ff, line_length_in;
   logic [7:0]       head_ff [sle_pkg::HEAD_DEPTH];
   logic [7:0]       head_in [sle_pkg::HEAD_DEPTH];
   logic             accept, is_bs, is_eol, append, match;

   assign req_tready = job_ready;
   assign job_valid  = req_tvalid;
   assign accept     = req_tvalid && job_ready;

   always_comb begin
      is_bs  = (req_tdata == sle_pkg::CHAR_BACKSPACE) || (req_tdata == sle_pkg::CHAR_DELETE);
      is_eol = (req_tdata == sle_pkg::CHAR_CR) || (req_tdata == sle_pkg::CHAR_LF);
      append = !is_bs && !is_eol && (line_length_ff < LEN_W'(LINE_DEPTH));

      line_length_in = line_length_ff;
      if (is_bs) begin
         if (line_length_ff != '0) line_length_in = line_length_ff - 1'b1;
      end else if (is_eol) begin
         line_length_in = '0;
      end else if (append) begin
         line_length_in = line_length_ff + 1'b1;
      end

      for (int i = 0; i < sle_pkg::HEAD_DEPTH; i++) begin
         head_in[i] = head_ff[i];
         if (append && line_length_ff == LEN_W'(i)) head_in[i] = req_tdata;
      end

      // greeting check on the line as it stands after this byte
      match = ((line_length_in == LEN_W'(2)) && head_in[0] == "h" && head_in[1] == "i")
           || ((line_length_in == LEN_W'(5)) && head_in[0] == "h" && head_in[1] == "e"
               && head_in[2] == "l" && head_in[3] == "l" && head_in[4] == "o");

      job.rx_byte = req_tdata;
      if (is_bs)       job.kind = sle_pkg::JOB_BACKSPACE;
      else if (is_eol) job.kind = sle_pkg::JOB_CLEAR;
      else if (match)  job.kind = sle_pkg::JOB_ECHO_REPLY;
      else             job.kind = sle_pkg::JOB_ECHO;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff <= '0;
      end else if (accept) begin
         line_length_ff <= line_length_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < sle_pkg::HEAD_DEPTH; i++) head_ff[i] <= head_in[i];
      end
   end

endmodule

/* sv/sle_queue.sv */
module sle_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  sle_pkg::job_type in_job,
   output logic             out_valid,
   input  logic             out_ready,
   output sle_pkg::job_type out_job
);

   sle_pkg::job_type              mem [sle_pkg::QUEUE_DEPTH];
   logic [sle_pkg::QUEUE_AW-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [sle_pkg::QUEUE_AW:0]    count_ff, count_in;
   logic                          push, pop;

   assign in_ready  = (count_ff != (sle_pkg::QUEUE_AW + 1)'(sle_pkg::QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_job   = mem[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem[wr_ptr_ff] <= in_job;
   end

endmodule

/* sv/sle_back.sv */
module sle_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   output logic             job_ready,
   input  sle_pkg::job_type job,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tuser,
   output logic             rsp_tlast
);

   sle_pkg::job_type   cur_ff, cur_in;
   logic               cur_valid_ff, cur_valid_in;
   logic [3:0]         step_ff, step_in;
   logic               rsp_valid_ff, rsp_valid_in;
   sle_pkg::write_type rsp_ff, w;
   logic               out_free, emit, finish, load;

   always_comb begin
      w        = sle_pkg::lcd_write(cur_ff, step_ff);
      out_free = !rsp_valid_ff || rsp_tready;
      emit     = cur_valid_ff && out_free;
      finish   = emit && w.last;
      // next job is taken in the same cycle the current one finishes
      job_ready = !cur_valid_ff || finish;
      load      = job_ready && job_valid;

      cur_in       = load ? job : cur_ff;
      cur_valid_in = load ? 1'b1 : (finish ? 1'b0 : cur_valid_ff);
      step_in      = load ? 4'd0 : (emit ? step_ff + 4'd1 : step_ff);
      rsp_valid_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= 4'd0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (emit) rsp_ff <= w;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff.lcd_byte;
   assign rsp_tuser  = rsp_ff.is_data;
   assign rsp_tlast  = rsp_ff.last;

endmodule
